[design/mlpf_pkg.sv]
package mlpf_pkg;

  localparam int PCT_FULL    = 100;
  localparam int PCT_RESET   = 37;
  localparam int DELAY_RESET = 1000;
  // floor(x / 100) == (x * 5243) >> 19 for every x below 43699
  localparam int DIV100_MUL  = 5243;
  localparam int DIV100_SH   = 19;
  localparam int PROD_W      = 14;
  localparam int QUOT_W      = PROD_W + 13;

  localparam logic [2:0] ACT_GET   = 3'd0;
  localparam logic [2:0] ACT_ALLOC = 3'd1;
  localparam logic [2:0] ACT_DIRTY = 3'd2;
  localparam logic [2:0] ACT_TICK  = 3'd3;
  localparam logic [2:0] ACT_FLUSH = 3'd4;

  localparam logic [1:0] KIND_DONE  = 2'd0;
  localparam logic [1:0] KIND_WRITE = 2'd1;
  localparam logic [1:0] KIND_FAIL  = 2'd2;

  localparam logic REG_OLD_PCT = 1'b0;
  localparam logic REG_DELAY   = 1'b1;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_CNT_RD,
    ST_CNT_WR,
    ST_SCAN_RD,
    ST_SCAN_CMP,
    ST_POS,
    ST_TAKE,
    ST_EVICT_RD,
    ST_EVICT_WB,
    ST_YL_MUL,
    ST_YL_DIV,
    ST_DECIDE,
    ST_MOVE,
    ST_INS,
    ST_REINIT,
    ST_MD_UPD,
    ST_FL_CHK,
    ST_FL_WB,
    ST_EMIT_WR,
    ST_EMIT_DONE,
    ST_EMIT_ZERO,
    ST_EMIT_FAIL
  } state_e;

  typedef struct packed {
    logic [31:0] stamp;
    logic [63:0] lsn;
    logic [7:0]  ptype;
    logic [23:0] page;
    logic [7:0]  space;
  } frame_t;

  typedef struct packed {
    logic        last;
    logic [63:0] lsn;
    logic [7:0]  ptype;
    logic [23:0] page;
    logic [7:0]  space;
    logic [3:0]  fidx;
    logic        hit;
    logic [1:0]  kind;
  } result_t;

endpackage

[design/mlpf_ram.sv]
module mlpf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[design/midpoint_lru_page_frame_manager_unit.sv]
// Get/allocate/mark dirty scan the tag store frame by frame, a read then a compare for each;
//   a get or allocation miss then shifts the list one slot per cycle to insert the frame,
//   and a get hit may move its frame to the head.
// Tick advances the tick counter; flush checks every frame and writes back each dirty one.
// One request at a time through an output register; a stalled sink holds the sequencer.
// Reset (async, active low) empties the list, clears valid/dirty, tick and page counters.
module midpoint_lru_page_frame_manager_unit
  import mlpf_pkg::*;
#(
  parameter int FRAMES = 16,
  parameter int SPACES = 128
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [103:0] s_axis_tdata,  // space, page number, page kind, lsn
  input  logic [2:0]   s_axis_tuser,  // action
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [111:0] m_axis_tdata,  // frame_index, out_space, out_page, out_type, out_lsn
  output logic [2:0]   m_axis_tuser,  // kind, hit
  output logic         m_axis_tlast,
  input  logic         cfg_we_i,
  input  logic         cfg_idx_i,
  input  logic [31:0]  cfg_data_i
);

  localparam int FW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int CW = $clog2(FRAMES + 1);
  localparam int SW = (SPACES > 1) ? $clog2(SPACES) : 1;

  state_e state_q, state_d;

  logic [2:0]    act_q;
  logic [7:0]    sp_q;
  logic [23:0]   pg_q;
  logic [7:0]    ty_q;
  logic [63:0]   lsn_q;
  logic [FW-1:0] f_q, free_q;
  logic          found_q, free_ok_q;
  frame_t        fd_q;
  logic [CW-1:0] cnt_q, count_q, y_q;
  logic [FW-1:0] pos_q;
  logic [PROD_W-1:0] prod_q;
  logic [31:0]   tick_q, delay_q;
  logic [6:0]    old_pct_q;
  logic [FRAMES-1:0] valid_q, dirty_q;
  logic [FW-1:0] rec_q [FRAMES];
  logic [SPACES-1:0] pc_valid_q;

  logic          ovld_q;
  result_t       ores_q;

  // memories
  logic          fe_we;
  logic [FW-1:0] fe_waddr, fe_raddr;
  frame_t        fe_wdata, fe_rdata;
  logic          pc_we;
  logic [23:0]   pc_wdata, pc_rdata;

  mlpf_ram #(.WIDTH($bits(frame_t)), .DEPTH(FRAMES)) u_frames (
    .clk_i  (clk_i),
    .we_i   (fe_we),
    .waddr_i(fe_waddr),
    .wdata_i(fe_wdata),
    .raddr_i(fe_raddr),
    .rdata_o(fe_rdata)
  );

  mlpf_ram #(.WIDTH(24), .DEPTH(SPACES)) u_page_ctr (
    .clk_i  (clk_i),
    .we_i   (pc_we),
    .waddr_i(sp_q[SW-1:0]),
    .wdata_i(pc_wdata),
    .raddr_i(sp_q[SW-1:0]),
    .rdata_o(pc_rdata)
  );

  // shared helpers
  logic          out_free;
  logic [FW-1:0] cidx, cidx_m1, tail_idx;
  logic          scan_last, scan_hit, sp_bad, promote;
  logic [6:0]    pct_eff;
  logic [QUOT_W-1:0] quot;
  logic [7:0]    ycalc;
  logic [CW-1:0] ynew;
  logic [23:0]   np;
  logic [63:0]   lsn_max;
  logic          emit_en;
  result_t       emit_r;

  assign out_free  = !ovld_q || m_axis_tready;
  assign cidx      = cnt_q[FW-1:0];
  assign cidx_m1   = FW'(cnt_q - 1'b1);
  assign tail_idx  = FW'(count_q - 1'b1);
  assign scan_last = (cnt_q == CW'(FRAMES - 1));
  assign scan_hit  = valid_q[cidx] && (fe_rdata.space == sp_q) && (fe_rdata.page == pg_q);
  assign sp_bad    = ({1'b0, sp_q} >= 9'(SPACES));
  assign pct_eff   = (old_pct_q > 7'(PCT_FULL)) ? 7'(PCT_FULL) : old_pct_q;
  assign quot      = QUOT_W'(prod_q) * QUOT_W'(DIV100_MUL);
  assign ycalc     = quot[DIV100_SH +: 8];
  assign ynew      = (count_q == '0) ? '0 : (ycalc == 8'd0) ? CW'(1) : CW'(ycalc);
  assign np        = pc_valid_q[sp_q[SW-1:0]] ? pc_rdata : 24'd0;
  assign lsn_max   = (lsn_q > fd_q.lsn) ? lsn_q : fd_q.lsn;
  assign promote   = (CW'(pos_q) < y_q) || ((tick_q - fd_q.stamp) > delay_q);

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = ovld_q;
  assign m_axis_tuser  = {ores_q.hit, ores_q.kind};
  assign m_axis_tlast  = ores_q.last;
  assign m_axis_tdata  = {4'd0, ores_q.lsn, ores_q.ptype, ores_q.page, ores_q.space, ores_q.fidx};

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:     if (s_axis_tvalid) state_d = ST_DISPATCH;
      ST_DISPATCH: begin
        case (act_q)
          ACT_GET, ACT_DIRTY: state_d = ST_SCAN_RD;
          ACT_ALLOC:          state_d = sp_bad ? ST_EMIT_FAIL : ST_CNT_RD;
          ACT_TICK:           state_d = ST_EMIT_ZERO;
          ACT_FLUSH:          state_d = ST_FL_CHK;
          default:            state_d = ST_EMIT_FAIL;
        endcase
      end
      ST_CNT_RD:   state_d = ST_CNT_WR;
      ST_CNT_WR:   state_d = ST_SCAN_RD;
      ST_SCAN_RD:  state_d = ST_SCAN_CMP;
      ST_SCAN_CMP: begin
        if (scan_hit) begin
          case (act_q)
            ACT_GET:   state_d = ST_POS;
            ACT_DIRTY: state_d = ST_MD_UPD;
            default:   state_d = ST_REINIT;
          endcase
        end else if (scan_last) begin
          state_d = (act_q == ACT_DIRTY) ? ST_EMIT_ZERO : ST_TAKE;
        end else begin
          state_d = ST_SCAN_RD;
        end
      end
      ST_POS:      if (rec_q[cidx] == f_q) state_d = ST_YL_MUL;
      ST_TAKE:     state_d = (count_q < CW'(FRAMES)) ? ST_YL_MUL : ST_EVICT_RD;
      ST_EVICT_RD: state_d = ST_EVICT_WB;
      ST_EVICT_WB: if (!dirty_q[f_q] || out_free) state_d = ST_YL_MUL;
      ST_YL_MUL:   state_d = ST_YL_DIV;
      ST_YL_DIV:   state_d = (act_q == ACT_GET && found_q) ? ST_DECIDE : ST_INS;
      ST_DECIDE:   state_d = promote ? ST_MOVE : ST_EMIT_DONE;
      ST_MOVE:     if (cnt_q == '0) state_d = ST_EMIT_DONE;
      ST_INS: begin
        if (cnt_q == y_q) state_d = (act_q == ACT_ALLOC) ? ST_EMIT_WR : ST_EMIT_DONE;
      end
      ST_REINIT:   state_d = ST_EMIT_WR;
      ST_MD_UPD:   state_d = ST_EMIT_DONE;
      ST_FL_CHK: begin
        if (valid_q[cidx] && dirty_q[cidx]) state_d = ST_FL_WB;
        else if (scan_last) state_d = ST_EMIT_ZERO;
      end
      ST_FL_WB:    if (out_free) state_d = scan_last ? ST_EMIT_ZERO : ST_FL_CHK;
      ST_EMIT_WR:  if (out_free) state_d = ST_EMIT_DONE;
      ST_EMIT_DONE, ST_EMIT_ZERO, ST_EMIT_FAIL: if (out_free) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  // memory controls and result selection
  always_comb begin
    fe_we    = 1'b0;
    fe_waddr = f_q;
    fe_wdata = fd_q;
    fe_raddr = f_q;
    pc_we    = 1'b0;
    pc_wdata = 24'(np + 24'd1);
    emit_en  = 1'b0;
    emit_r   = '0;
    case (state_q)
      ST_CNT_WR:   pc_we = 1'b1;
      ST_SCAN_RD, ST_SCAN_CMP, ST_FL_CHK, ST_FL_WB: fe_raddr = cidx;
      default: ;
    endcase
    case (state_q)
      ST_INS: begin
        fe_we    = (cnt_q == y_q);
        fe_wdata = '{stamp: tick_q, lsn: (act_q == ACT_ALLOC) ? 64'd0 : lsn_q,
                     ptype: ty_q, page: pg_q, space: sp_q};
      end
      ST_REINIT: begin
        fe_we    = 1'b1;
        fe_wdata = '{stamp: tick_q, lsn: 64'd0, ptype: ty_q, page: fd_q.page,
                     space: fd_q.space};
      end
      ST_MD_UPD: begin
        fe_we    = 1'b1;
        fe_wdata = '{stamp: fd_q.stamp, lsn: lsn_max, ptype: fd_q.ptype, page: fd_q.page,
                     space: fd_q.space};
      end
      ST_EVICT_WB: begin
        emit_en = dirty_q[f_q] && out_free;
        emit_r  = '{last: 1'b0, lsn: fe_rdata.lsn, ptype: fe_rdata.ptype,
                    page: fe_rdata.page, space: fe_rdata.space, fidx: 4'(f_q),
                    hit: 1'b0, kind: KIND_WRITE};
      end
      ST_FL_WB: begin
        emit_en = out_free;
        emit_r  = '{last: 1'b0, lsn: fe_rdata.lsn, ptype: fe_rdata.ptype,
                    page: fe_rdata.page, space: fe_rdata.space, fidx: 4'(cidx),
                    hit: 1'b0, kind: KIND_WRITE};
      end
      ST_EMIT_WR, ST_EMIT_DONE: begin
        emit_en = out_free;
        emit_r  = '{last: (state_q == ST_EMIT_DONE), lsn: fd_q.lsn, ptype: fd_q.ptype,
                    page: fd_q.page, space: fd_q.space, fidx: 4'(f_q),
                    hit: (state_q == ST_EMIT_DONE) && found_q,
                    kind: (state_q == ST_EMIT_DONE) ? KIND_DONE : KIND_WRITE};
      end
      ST_EMIT_ZERO: begin
        emit_en     = out_free;
        emit_r.last = 1'b1;
        emit_r.kind = KIND_DONE;
      end
      ST_EMIT_FAIL: begin
        emit_en     = out_free;
        emit_r.last = 1'b1;
        emit_r.kind = KIND_FAIL;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      ovld_q     <= 1'b0;
      count_q    <= '0;
      tick_q     <= '0;
      valid_q    <= '0;
      dirty_q    <= '0;
      pc_valid_q <= '0;
      old_pct_q  <= 7'(PCT_RESET);
      delay_q    <= 32'(DELAY_RESET);
      cnt_q      <= '0;
      found_q    <= 1'b0;
      free_ok_q  <= 1'b0;
      for (int i = 0; i < FRAMES; i++) rec_q[i] <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_OLD_PCT) old_pct_q <= cfg_data_i[6:0];
        if (cfg_idx_i == REG_DELAY)   delay_q   <= cfg_data_i;
      end
      if (emit_en) begin
        ovld_q <= 1'b1;
      end else if (m_axis_tready) begin
        ovld_q <= 1'b0;
      end
      case (state_q)
        ST_DISPATCH: begin
          cnt_q     <= '0;
          found_q   <= 1'b0;
          free_ok_q <= 1'b0;
          if (act_q == ACT_TICK) tick_q <= tick_q + 32'd1;
        end
        ST_CNT_WR: begin
          pc_valid_q[sp_q[SW-1:0]] <= 1'b1;
        end
        ST_SCAN_CMP: begin
          if (scan_hit) begin
            found_q <= 1'b1;
            cnt_q   <= '0;
          end else begin
            if (!valid_q[cidx] && !free_ok_q) free_ok_q <= 1'b1;
            cnt_q <= cnt_q + 1'b1;
          end
        end
        ST_POS: begin
          if (rec_q[cidx] != f_q) cnt_q <= cnt_q + 1'b1;
        end
        ST_TAKE: begin
          // full: drop the tail from the list
          if (count_q == CW'(FRAMES)) count_q <= count_q - 1'b1;
        end
        ST_EVICT_WB: begin
          if (!dirty_q[f_q] || out_free) begin
            valid_q[f_q] <= 1'b0;
            dirty_q[f_q] <= 1'b0;
          end
        end
        ST_YL_DIV: cnt_q <= count_q;
        ST_DECIDE: cnt_q <= CW'(pos_q);
        ST_MOVE: begin
          if (cnt_q == '0) begin
            rec_q[0] <= f_q;
          end else begin
            rec_q[cidx] <= rec_q[cidx_m1];
            cnt_q       <= cnt_q - 1'b1;
          end
        end
        ST_INS: begin
          if (cnt_q == y_q) begin
            rec_q[cidx]  <= f_q;
            count_q      <= count_q + 1'b1;
            valid_q[f_q] <= 1'b1;
            dirty_q[f_q] <= (act_q == ACT_ALLOC);
          end else begin
            rec_q[cidx] <= rec_q[cidx_m1];
            cnt_q       <= cnt_q - 1'b1;
          end
        end
        ST_REINIT, ST_MD_UPD: dirty_q[f_q] <= 1'b1;
        ST_FL_CHK: begin
          if (!(valid_q[cidx] && dirty_q[cidx]) && !scan_last) cnt_q <= cnt_q + 1'b1;
        end
        ST_FL_WB: begin
          if (out_free) begin
            dirty_q[cidx] <= 1'b0;
            if (!scan_last) cnt_q <= cnt_q + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && s_axis_tvalid) begin
      act_q <= s_axis_tuser;
      sp_q  <= s_axis_tdata[7:0];
      pg_q  <= s_axis_tdata[31:8];
      ty_q  <= s_axis_tdata[39:32];
      lsn_q <= s_axis_tdata[103:40];
    end
    if (emit_en) ores_q <= emit_r;
    case (state_q)
      ST_CNT_WR: pg_q <= np;
      ST_SCAN_CMP: begin
        if (scan_hit) begin
          f_q  <= cidx;
          fd_q <= fe_rdata;
        end else if (!valid_q[cidx] && !free_ok_q) begin
          free_q <= cidx;
        end
      end
      ST_POS: if (rec_q[cidx] == f_q) pos_q <= cidx;
      ST_TAKE: f_q <= (count_q < CW'(FRAMES)) ? free_q : rec_q[tail_idx];
      ST_YL_MUL: prod_q <= PROD_W'(count_q) * PROD_W'(7'(PCT_FULL) - pct_eff);
      ST_YL_DIV: y_q <= ynew;
      ST_INS, ST_REINIT, ST_MD_UPD: if (fe_we) fd_q <= fe_wdata;
      default: ;
    endcase
  end

  a_count_matches_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_IDLE |-> $countones(valid_q) == int'(count_q))
    else $error("resident count disagrees with valid frames");

  a_dirty_implies_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_IDLE |-> (dirty_q & ~valid_q) == '0)
    else $error("dirty frame is not valid");

  a_tick_only_on_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(tick_q) |-> $past(state_q) == ST_DISPATCH && $past(act_q) == ACT_TICK)
    else $error("tick counter moved outside a tick request");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(count_q) <= FRAMES)
    else $error("resident count above frame total");

endmodule

[test/tb.sv]
module tb;
  import mlpf_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAMES = 16;
  localparam int SPACES = 128;
  localparam int PHASE_ITEMS = 33;

  class frame_tracker;
    bit          valid [FRAMES];
    logic [7:0]  space [FRAMES];
    logic [23:0] page [FRAMES];
    logic [7:0]  ptype [FRAMES];
    bit          dirty [FRAMES];
    logic [63:0] lsn [FRAMES];
    logic [31:0] stamp [FRAMES];
    int unsigned order [FRAMES];
    int unsigned count;
    logic [31:0] now;
    logic [23:0] next_page [SPACES];
    logic [6:0]  old_pct;
    logic [31:0] delay;
    result_t     pending_results[$];
    int          errors;

    function new();
      count = 0;
      now = '0;
      old_pct = 7'(PCT_RESET);
      delay = 32'(DELAY_RESET);
      errors = 0;
      foreach (valid[i]) begin
        valid[i] = 0;
        dirty[i] = 0;
      end
      foreach (next_page[i]) next_page[i] = '0;
    endfunction

    function void set_reg(logic idx, logic [31:0] data);
      if (idx == REG_OLD_PCT) old_pct = data[6:0];
      else delay = data;
    endfunction

    function int unsigned young(int unsigned cnt);
      int unsigned pct;
      int unsigned y;
      pct = (old_pct > 100) ? 100 : old_pct;
      if (cnt == 0) return 0;
      y = cnt * (100 - pct) / 100;
      return (y == 0) ? 1 : y;
    endfunction

    function void push(logic [1:0] kind, logic hit, int unsigned f, logic [7:0] sp,
                       logic [23:0] pg, logic [7:0] ty, logic [63:0] l);
      result_t r;
      r.kind = kind;
      r.hit = hit;
      r.fidx = f[3:0];
      r.space = sp;
      r.page = pg;
      r.ptype = ty;
      r.lsn = l;
      r.last = 1'b0;
      pending_results.push_back(r);
    endfunction

    function void push_frame(logic [1:0] kind, logic hit, int unsigned f);
      push(kind, hit, f, space[f], page[f], ptype[f], lsn[f]);
    endfunction

    function int find(logic [7:0] sp, logic [23:0] pg);
      for (int i = 0; i < FRAMES; i++)
        if (valid[i] && space[i] == sp && page[i] == pg) return i;
      return -1;
    endfunction

    function int unsigned pos_of(int unsigned f);
      for (int unsigned i = 0; i < count; i++)
        if (order[i] == f) return i;
      return 0;
    endfunction

    function void remove_at(int unsigned p);
      for (int unsigned i = p; i + 1 < count; i++) order[i] = order[i + 1];
      count--;
    endfunction

    function void insert_at(int unsigned p, int unsigned f);
      for (int unsigned i = count; i > p; i--) order[i] = order[i - 1];
      order[p] = f;
      count++;
    endfunction

    // lowest free frame, or evict the tail with a write-back if dirty
    function int unsigned take_frame();
      int unsigned v;
      if (count < FRAMES)
        for (int unsigned i = 0; i < FRAMES; i++)
          if (!valid[i]) return i;
      v = order[count - 1];
      remove_at(count - 1);
      if (dirty[v]) push_frame(KIND_WRITE, 1'b0, v);
      valid[v] = 0;
      dirty[v] = 0;
      return v;
    endfunction

    function void place(int unsigned f, logic [7:0] sp, logic [23:0] pg, logic [7:0] ty,
                        logic [63:0] l, bit d);
      int unsigned y;
      y = young(count);
      valid[f] = 1;
      space[f] = sp;
      page[f] = pg;
      ptype[f] = ty;
      lsn[f] = l;
      dirty[f] = d;
      stamp[f] = now;
      insert_at((y < count) ? y : count, f);
    endfunction

    function void note_request(logic [2:0] act, logic [7:0] sp, logic [23:0] pg,
                               logic [7:0] ty, logic [63:0] l);
      int idx;
      int unsigned f;
      int unsigned p;
      logic [31:0] age;
      logic [23:0] np;
      case (act)
        ACT_GET: begin
          idx = find(sp, pg);
          if (idx >= 0) begin
            f = idx;
            p = pos_of(f);
            age = now - stamp[f];
            if (p < young(count) || age > delay) begin
              remove_at(p);
              insert_at(0, f);
            end
            push_frame(KIND_DONE, 1'b1, f);
          end else begin
            f = take_frame();
            place(f, sp, pg, ty, l, 1'b0);
            push_frame(KIND_DONE, 1'b0, f);
          end
        end
        ACT_ALLOC: begin
          if (sp >= SPACES) begin
            push(KIND_FAIL, 1'b0, 0, '0, '0, '0, '0);
          end else begin
            np = next_page[sp];
            next_page[sp] = np + 1'b1;
            idx = find(sp, np);
            if (idx >= 0) begin
              f = idx;
              ptype[f] = ty;
              lsn[f] = '0;
              dirty[f] = 1;
              stamp[f] = now;
              push_frame(KIND_WRITE, 1'b0, f);
              push_frame(KIND_DONE, 1'b1, f);
            end else begin
              f = take_frame();
              place(f, sp, np, ty, '0, 1'b1);
              push_frame(KIND_WRITE, 1'b0, f);
              push_frame(KIND_DONE, 1'b0, f);
            end
          end
        end
        ACT_DIRTY: begin
          idx = find(sp, pg);
          if (idx >= 0) begin
            f = idx;
            dirty[f] = 1;
            if (l > lsn[f]) lsn[f] = l;
            push_frame(KIND_DONE, 1'b1, f);
          end else begin
            push(KIND_DONE, 1'b0, 0, '0, '0, '0, '0);
          end
        end
        ACT_TICK: begin
          now = now + 32'd1;
          push(KIND_DONE, 1'b0, 0, '0, '0, '0, '0);
        end
        ACT_FLUSH: begin
          for (int unsigned i = 0; i < FRAMES; i++)
            if (valid[i] && dirty[i]) begin
              push_frame(KIND_WRITE, 1'b0, i);
              dirty[i] = 0;
            end
          push(KIND_DONE, 1'b0, 0, '0, '0, '0, '0);
        end
        default: push(KIND_FAIL, 1'b0, 0, '0, '0, '0, '0);
      endcase
      pending_results[$].last = 1'b1;
    endfunction

    task report(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
      errors++;
    endtask

    task check_result(result_t got);
      result_t want;
      if (pending_results.size() == 0) begin
        report("unexpected result", 64'(got), '0);
      end else begin
        want = pending_results.pop_front();
        if (got.kind != want.kind) report("kind", 64'(got.kind), 64'(want.kind));
        if (got.hit != want.hit) report("hit", 64'(got.hit), 64'(want.hit));
        if (got.fidx != want.fidx) report("frame_index", 64'(got.fidx), 64'(want.fidx));
        if (got.space != want.space) report("out_space", 64'(got.space), 64'(want.space));
        if (got.page != want.page) report("out_page", 64'(got.page), 64'(want.page));
        if (got.ptype != want.ptype) report("out_type", 64'(got.ptype), 64'(want.ptype));
        if (got.lsn != want.lsn) report("out_lsn", got.lsn, want.lsn);
        if (got.last != want.last) report("last", 64'(got.last), 64'(want.last));
      end
    endtask
  endclass

  logic         clk_i = 0;
  logic         rst_ni = 0;
  logic         s_axis_tvalid = 0;
  logic         s_axis_tready;
  logic [103:0] s_axis_tdata = '0;
  logic [2:0]   s_axis_tuser = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 0;
  logic [111:0] m_axis_tdata;
  logic [2:0]   m_axis_tuser;
  logic         m_axis_tlast;
  logic         cfg_we_i = 0;
  logic         cfg_idx_i = 0;
  logic [31:0]  cfg_data_i = '0;

  frame_tracker tracker = new();
  bit calm = 0;
  bit long_hold = 0;

  midpoint_lru_page_frame_manager_unit #(.FRAMES(FRAMES), .SPACES(SPACES)) dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    result_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.kind = m_axis_tuser[1:0];
      got.hit = m_axis_tuser[2];
      got.fidx = m_axis_tdata[3:0];
      got.space = m_axis_tdata[11:4];
      got.page = m_axis_tdata[35:12];
      got.ptype = m_axis_tdata[43:36];
      got.lsn = m_axis_tdata[107:44];
      got.last = m_axis_tlast;
      tracker.check_result(got);
    end
  end

  // sink side: random stalls, plus one long hold to back up the block
  always begin
    @(negedge clk_i);
    if (long_hold) begin
      m_axis_tready <= 1'b0;
      repeat (399) @(negedge clk_i);
      long_hold = 0;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      m_axis_tready <= 1'b0;
      repeat ($urandom_range(0, 10)) @(negedge clk_i);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  task send(logic [2:0] act, logic [7:0] sp, logic [23:0] pg, logic [7:0] ty,
            logic [63:0] l);
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= act;
    s_axis_tdata <= {l, ty, pg, sp};
    do @(posedge clk_i); while (!s_axis_tready);
    tracker.note_request(act, sp, pg, ty, l);
  endtask

  task pause_sender(int unsigned n);
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    repeat (n - 1) @(negedge clk_i);
  endtask

  task drain();
    pause_sender(1);
    while (tracker.pending_results.size() != 0) @(negedge clk_i);
    repeat (80) @(negedge clk_i);
  endtask

  task write_reg(logic idx, logic [31:0] data);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    tracker.set_reg(idx, data);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task random_request();
    logic [2:0]  act;
    logic [7:0]  sp;
    logic [23:0] pg;
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 40) act = ACT_GET;
    else if (r < 56) act = ACT_ALLOC;
    else if (r < 71) act = ACT_DIRTY;
    else if (r < 87) act = ACT_TICK;
    else if (r < 96) act = ACT_FLUSH;
    else act = 3'($urandom_range(5, 7));
    r = $urandom_range(0, 99);
    if (r < 85) sp = 8'($urandom_range(0, 3));
    else if (r < 90) sp = 8'($urandom_range(126, 129));
    else sp = 8'($urandom);
    pg = ($urandom_range(0, 99) < 85) ? 24'($urandom_range(0, 23)) : 24'($urandom);
    send(act, sp, pg, 8'($urandom), {$urandom, $urandom});
    if (!calm && $urandom_range(0, 4) == 0) pause_sender($urandom_range(1, 11));
  endtask

  initial begin
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    write_reg(REG_OLD_PCT, PCT_RESET);
    write_reg(REG_DELAY, DELAY_RESET);

    send(ACT_GET, 8'd0, 24'd5, 8'hFF, '1);
    send(ACT_GET, 8'd0, 24'd5, 8'h00, '0);
    send(ACT_ALLOC, 8'd0, 24'd0, 8'h00, '0);
    send(ACT_GET, 8'd0, 24'd0, 8'h11, 64'd7);
    send(ACT_GET, 8'd0, 24'd1, 8'h22, 64'd9);
    // allocation draws page 1, which is already resident
    send(ACT_ALLOC, 8'd0, 24'd0, 8'hAB, '0);
    send(ACT_DIRTY, 8'd0, 24'd5, 8'h00, 64'd100);
    send(ACT_DIRTY, 8'd0, 24'd1, 8'h00, 64'h8000_0000_0000_0000);
    send(ACT_DIRTY, 8'hFF, 24'hFFFFFF, 8'hFF, '1);
    send(ACT_ALLOC, 8'hFF, 24'd0, 8'h00, '0);
    send(ACT_ALLOC, 8'd128, 24'd0, 8'h00, '0);
    send(ACT_ALLOC, 8'd127, 24'hFFFFFF, 8'h5A, '1);
    send(ACT_GET, 8'hFF, 24'hFFFFFF, 8'h00, '0);
    send(ACT_TICK, 8'd0, 24'd0, 8'h00, '0);
    send(ACT_FLUSH, 8'd0, 24'd0, 8'h00, '0);
    send(3'd5, 8'd0, 24'd0, 8'h00, '0);
    send(3'd6, 8'hFF, 24'hFFFFFF, 8'hFF, '1);
    send(3'd7, 8'd0, 24'd0, 8'h00, '0);
    send(ACT_FLUSH, 8'd0, 24'd0, 8'h00, '0);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin write_reg(REG_OLD_PCT, 32'd0);   write_reg(REG_DELAY, 32'd0); end
        1: begin write_reg(REG_OLD_PCT, 32'd100); write_reg(REG_DELAY, 32'hFFFF_FFFF); end
        2: begin write_reg(REG_OLD_PCT, 32'd127); write_reg(REG_DELAY, 32'd2); end
        default: begin
          write_reg(REG_OLD_PCT, 32'd37);
          write_reg(REG_DELAY, 32'd3);
        end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (ph == 1 && n == 3) long_hold = 1;
        if (ph == 3 && n == PHASE_ITEMS / 2) calm = 1;
        random_request();
      end
      drain();
    end

    if (tracker.errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
